[src/qct_pkg.sv]
// Shared types and constants for the queen conflict tracker.
// Used by qct_update, qct_index and queen_conflict_tracker_unit.
package qct_pkg;

    localparam int CNT_W   = 11;
    localparam int TOTAL_W = 12;
    localparam int COORD_W = 10;
    localparam int WORK_W  = 15;   // width of the unreduced index values

    typedef logic [CNT_W-1:0]   cnt_t;
    typedef logic [TOTAL_W-1:0] total_t;
    typedef logic [COORD_W-1:0] coord_t;

    localparam cnt_t   CNT_MAX   = 11'd2047;
    localparam total_t TOTAL_MAX = 12'd4095;
    localparam cnt_t   EMPTY_COL = 11'd2047;

    localparam logic OP_PLACE  = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    // Line counts and stored queen column read for one request
    typedef struct packed {
        cnt_t row_cnt;
        cnt_t col_cnt;
        cnt_t sum_cnt;
        cnt_t diff_cnt;
        cnt_t queen_col;
    } line_rec_t;

    // Outcome of one request
    typedef struct packed {
        logic   wr;
        logic   ok;
        total_t total;
        logic   attacked;
    } upd_res_t;

endpackage

[src/qct_ram.sv]
// Single-port-write, single-port-read synchronous memory with a registered read.
// No dependencies.
module qct_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 11
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

[src/qct_index.sv]
// Line index generation: row, column and both diagonal addresses, wrapped to
// the memory depths by constant compare-and-subtract steps. Uses qct_pkg.
module qct_index import qct_pkg::*; #(
    parameter int MAX_N = 1024
) (
    input  coord_t                       row,
    input  coord_t                       col,
    input  cnt_t                         board_size,
    output logic [$clog2(MAX_N)-1:0]     ri,
    output logic [$clog2(MAX_N)-1:0]     ci,
    output logic [$clog2(2*MAX_N)-1:0]   si,
    output logic [$clog2(2*MAX_N)-1:0]   di
);

    localparam int RIW  = $clog2(MAX_N);
    localparam int DIW  = $clog2(2*MAX_N);
    localparam int M2   = 2*MAX_N;
    localparam int RMAX = 1023;
    localparam int SMAX = 2046;
    // bias keeps row - col + board_size nonnegative, a multiple of M2
    localparam int BIAS = M2 * ((RMAX + M2 - 1) / M2);
    localparam int DMAX = RMAX + 2047 + BIAS;

    always_comb begin
        logic [WORK_W-1:0] xr;
        logic [WORK_W-1:0] xc;
        logic [WORK_W-1:0] xs;
        logic [WORK_W-1:0] xd;
        xr = WORK_W'(row);
        xc = WORK_W'(col);
        xs = WORK_W'(row) + WORK_W'(col);
        xd = WORK_W'(row) + WORK_W'(BIAS) + WORK_W'(board_size) - WORK_W'(col);
        // only the steps whose multiple can fit below the max value survive
        for (int k = 11; k >= 0; k--) begin
            if ((MAX_N << k) <= RMAX) begin
                if (xr >= WORK_W'(MAX_N << k)) xr = xr - WORK_W'(MAX_N << k);
                if (xc >= WORK_W'(MAX_N << k)) xc = xc - WORK_W'(MAX_N << k);
            end
            if ((M2 << k) <= SMAX) begin
                if (xs >= WORK_W'(M2 << k)) xs = xs - WORK_W'(M2 << k);
            end
            if ((M2 << k) <= DMAX) begin
                if (xd >= WORK_W'(M2 << k)) xd = xd - WORK_W'(M2 << k);
            end
        end
        ri = xr[RIW-1:0];
        ci = xc[RIW-1:0];
        si = xs[DIW-1:0];
        di = xd[DIW-1:0];
    end

endmodule

[src/qct_update.sv]
// Modify step of the read-modify-write: new line counts, conflict total,
// attack flag and remove check. Uses qct_pkg.
module qct_update import qct_pkg::*; (
    input  logic      op,
    input  coord_t    col,
    input  line_rec_t cur,
    input  total_t    conflicts,
    output line_rec_t nxt,
    output upd_res_t  res
);

    function automatic cnt_t sat_inc(input cnt_t c);
        return (c == CNT_MAX) ? c : c + 11'd1;
    endfunction

    function automatic cnt_t sat_dec(input cnt_t c);
        return (c == '0) ? c : c - 11'd1;
    endfunction

    function automatic logic [2:0] multi(input cnt_t c);
        return {2'b00, (c > 11'd1)};
    endfunction

    line_rec_t  inc;
    logic [2:0] n_place;
    logic [2:0] n_remove;
    logic [12:0] sum_place;
    logic       match;

    always_comb begin
        inc.row_cnt   = sat_inc(cur.row_cnt);
        inc.col_cnt   = sat_inc(cur.col_cnt);
        inc.sum_cnt   = sat_inc(cur.sum_cnt);
        inc.diff_cnt  = sat_inc(cur.diff_cnt);
        inc.queen_col = {1'b0, col};

        n_place  = multi(inc.row_cnt) + multi(inc.col_cnt)
                 + multi(inc.sum_cnt) + multi(inc.diff_cnt);
        n_remove = multi(cur.row_cnt) + multi(cur.col_cnt)
                 + multi(cur.sum_cnt) + multi(cur.diff_cnt);
        sum_place = {1'b0, conflicts} + 13'(n_place);
        match = (cur.queen_col == {1'b0, col});

        nxt = inc;
        res.wr       = 1'b1;
        res.ok       = 1'b1;
        res.attacked = 1'b0;
        res.total    = conflicts;
        if (op == OP_PLACE) begin
            res.total    = sum_place[12] ? TOTAL_MAX : sum_place[11:0];
            res.attacked = (inc.col_cnt > 11'd1) || (inc.sum_cnt > 11'd1)
                        || (inc.diff_cnt > 11'd1);
        end else begin
            nxt.row_cnt   = sat_dec(cur.row_cnt);
            nxt.col_cnt   = sat_dec(cur.col_cnt);
            nxt.sum_cnt   = sat_dec(cur.sum_cnt);
            nxt.diff_cnt  = sat_dec(cur.diff_cnt);
            nxt.queen_col = EMPTY_COL;
            if (!match) begin
                res.wr = 1'b0;
                res.ok = 1'b0;
            end else if (conflicts < 12'(n_remove)) begin
                res.total = '0;
            end else begin
                res.total = conflicts - 12'(n_remove);
            end
        end
    end

endmodule

[src/queen_conflict_tracker_unit.sv]
// Queen conflict tracker: line occupancy counters in on-chip memories.
// Flow: the memory read is registered on accept; update and write-back run in ST_EXEC,
// then the result is registered. New requests wait for ST_IDLE and a free result slot.
// Reset: a clearing pass zeroes all memories through all 2*MAX_N addresses (2048 at the
// default), during which s_tready stays low; config writes are taken as ever.
module queen_conflict_tracker_unit import qct_pkg::*; #(
    parameter int MAX_N = 1024
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [10:0] cfg_wdata,     // board_size
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,       // op [0], row [10:1], col [20:11], zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata        // ok [0], conflict_total [12:1], attacked [13]
);

    localparam int RIW = $clog2(MAX_N);
    localparam int DIW = $clog2(2*MAX_N);

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_EXEC  = 2'd2;

    logic [1:0]     state_reg, state_next;
    logic [DIW-1:0] clr_addr_reg;
    cnt_t           board_size_reg;
    total_t         conflicts_reg;
    logic           m_tvalid_reg;
    logic [15:0]    m_tdata_reg;

    logic           op_reg;
    coord_t         col_reg;
    logic [RIW-1:0] ri_reg, ci_reg;
    logic [DIW-1:0] si_reg, di_reg;

    logic [RIW-1:0] ri, ci;
    logic [DIW-1:0] si, di;
    logic           accept;
    logic           clearing;
    logic           exec_wr;
    logic           clr_low;

    line_rec_t cur, nxt;
    upd_res_t  upd;

    assign clearing = (state_reg == ST_CLEAR);
    assign s_tready = (state_reg == ST_IDLE) && (!m_tvalid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;
    assign exec_wr  = (state_reg == ST_EXEC) && upd.wr;
    assign clr_low  = (clr_addr_reg < DIW'(MAX_N));
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    qct_index #(.MAX_N(MAX_N)) u_index (
        .row        (s_tdata[10:1]),
        .col        (s_tdata[20:11]),
        .board_size (board_size_reg),
        .ri         (ri),
        .ci         (ci),
        .si         (si),
        .di         (di)
    );

    qct_ram #(.DEPTH(MAX_N), .WIDTH(2*CNT_W)) u_row_mem (
        .aclk  (aclk),
        .we    (clearing ? clr_low : exec_wr),
        .waddr (clearing ? clr_addr_reg[RIW-1:0] : ri_reg),
        .wdata (clearing ? '0 : {nxt.queen_col, nxt.row_cnt}),
        .re    (accept),
        .raddr (ri),
        .rdata ({cur.queen_col, cur.row_cnt})
    );

    qct_ram #(.DEPTH(MAX_N), .WIDTH(CNT_W)) u_col_mem (
        .aclk  (aclk),
        .we    (clearing ? clr_low : exec_wr),
        .waddr (clearing ? clr_addr_reg[RIW-1:0] : ci_reg),
        .wdata (clearing ? '0 : nxt.col_cnt),
        .re    (accept),
        .raddr (ci),
        .rdata (cur.col_cnt)
    );

    qct_ram #(.DEPTH(2*MAX_N), .WIDTH(CNT_W)) u_sum_mem (
        .aclk  (aclk),
        .we    (clearing || exec_wr),
        .waddr (clearing ? clr_addr_reg : si_reg),
        .wdata (clearing ? '0 : nxt.sum_cnt),
        .re    (accept),
        .raddr (si),
        .rdata (cur.sum_cnt)
    );

    qct_ram #(.DEPTH(2*MAX_N), .WIDTH(CNT_W)) u_diff_mem (
        .aclk  (aclk),
        .we    (clearing || exec_wr),
        .waddr (clearing ? clr_addr_reg : di_reg),
        .wdata (clearing ? '0 : nxt.diff_cnt),
        .re    (accept),
        .raddr (di),
        .rdata (cur.diff_cnt)
    );

    qct_update u_update (
        .op        (op_reg),
        .col       (col_reg),
        .cur       (cur),
        .conflicts (conflicts_reg),
        .nxt       (nxt),
        .res       (upd)
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: if (clr_addr_reg == DIW'(2*MAX_N - 1)) state_next = ST_IDLE;
            ST_IDLE:  if (accept) state_next = ST_EXEC;
            ST_EXEC:  state_next = ST_IDLE;
            default:  state_next = ST_CLEAR;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_CLEAR;
            clr_addr_reg   <= '0;
            board_size_reg <= 11'd8;
            conflicts_reg  <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (clearing) clr_addr_reg <= clr_addr_reg + DIW'(1);
            if (cfg_we) board_size_reg <= cfg_wdata;
            if (state_reg == ST_EXEC) begin
                conflicts_reg <= upd.total;
                m_tvalid_reg  <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg  <= 1'b0;
            end
        end
    end

    // request payload and result payload, no reset
    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg  <= s_tdata[0];
            col_reg <= s_tdata[20:11];
            ri_reg  <= ri;
            ci_reg  <= ci;
            si_reg  <= si;
            di_reg  <= di;
        end
        if (state_reg == ST_EXEC) begin
            m_tdata_reg <= {2'b00, upd.attacked, upd.total, upd.ok};
        end
    end

    a_no_accept_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        clearing |-> !s_tready)
        else $error("request accepted during clearing pass");

    a_accept_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (state_reg == ST_EXEC))
        else $error("accepted request not executed next cycle");

    a_result_from_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> ($past(state_reg) == ST_EXEC))
        else $error("result appeared without an executed request");

    a_refused_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_EXEC) && !upd.ok) |=> $stable(conflicts_reg))
        else $error("refused remove changed the conflict total");

endmodule

[tb/tb.sv]
// Self-checking bench for queen_conflict_tracker_unit: drives place/remove requests
// and compares each result with a behavioral tracker of the board.
// Depends on qct_pkg and the tracker RTL only.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import qct_pkg::*;

    localparam int MAX_N = 1024;
    localparam int LIMIT = 500_000;

    typedef struct {
        logic   op;
        coord_t row;
        coord_t col;
    } move_t;

    typedef struct {
        logic   ok;
        total_t total;
        logic   attacked;
    } outcome_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [10:0] cfg_wdata = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata   = '0;    // op [0], row [10:1], col [20:11], zero pad
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [15:0] m_tdata;           // ok [0], conflict_total [12:1], attacked [13]

    queen_conflict_tracker_unit #(.MAX_N(MAX_N)) u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // Tracker copy of the board
    cnt_t        line_row_cnt  [MAX_N];
    cnt_t        line_col_cnt  [MAX_N];
    cnt_t        line_sum_cnt  [2*MAX_N];
    cnt_t        line_diff_cnt [2*MAX_N];
    cnt_t        row_queen_col [MAX_N];
    total_t      conflict_sum;
    logic [10:0] board_size_q;

    // Stimulus side view of the recorded queen column, used to build legal removes
    cnt_t        plan_col [MAX_N];

    move_t       move_queue[$];
    outcome_t    awaited_outcomes[$];

    logic        req_fire  = 1'b0;
    logic        resp_fire = 1'b0;
    int          src_wait  = 0;
    int          sink_wait = 0;
    int          src_idle_max  = 14;
    int          sink_idle_max = 14;

    int          cycle_count    = 0;
    int          mismatch_count = 0;
    int          n_place = 0, n_remove = 0, n_refused = 0, n_attacked = 0;
    int          n_settings = 0;
    int          peak_total = 0;

    initial begin
        forever #2 aclk = ~aclk;
    end

    function automatic cnt_t line_up(cnt_t c);
        cnt_t n;
        n = (c < CNT_MAX) ? c + 1'b1 : c;
        if (n > 1 && conflict_sum < TOTAL_MAX) conflict_sum = conflict_sum + 1'b1;
        return n;
    endfunction

    function automatic cnt_t line_down(cnt_t c);
        if (c > 1 && conflict_sum > 0) conflict_sum = conflict_sum - 1'b1;
        return (c > 0) ? c - 1'b1 : c;
    endfunction

    function automatic outcome_t apply_move(move_t mv);
        int unsigned si;
        int unsigned di;
        cnt_t        cc, sc, dc;
        outcome_t    res;
        si = mv.row + mv.col;
        // difference diagonal, taken as a nonnegative residue
        di = (2 * MAX_N + mv.row + board_size_q - mv.col) % (2 * MAX_N);
        res.ok = 1'b1;
        res.attacked = 1'b0;
        if (mv.op == OP_PLACE) begin
            line_row_cnt[mv.row] = line_up(line_row_cnt[mv.row]);
            cc = line_up(line_col_cnt[mv.col]);
            sc = line_up(line_sum_cnt[si]);
            dc = line_up(line_diff_cnt[di]);
            line_col_cnt[mv.col] = cc;
            line_sum_cnt[si] = sc;
            line_diff_cnt[di] = dc;
            row_queen_col[mv.row] = {1'b0, mv.col};
            res.attacked = (cc > 1 || sc > 1 || dc > 1);
        end else if (row_queen_col[mv.row] != {1'b0, mv.col}) begin
            res.ok = 1'b0;
        end else begin
            line_row_cnt[mv.row] = line_down(line_row_cnt[mv.row]);
            line_col_cnt[mv.col] = line_down(line_col_cnt[mv.col]);
            line_sum_cnt[si] = line_down(line_sum_cnt[si]);
            line_diff_cnt[di] = line_down(line_diff_cnt[di]);
            row_queen_col[mv.row] = EMPTY_COL;
        end
        res.total = conflict_sum;
        return res;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        mismatch_count++;
        if (mismatch_count <= 100)
            $display("MISMATCH cycle %0d: %s got %0d, expected %0d", cycle_count, what, got,
                     want);
    endtask

    task automatic queue_move(logic op, int unsigned row, int unsigned col);
        move_t mv;
        mv.op  = op;
        mv.row = row[9:0];
        mv.col = col[9:0];
        if (op == OP_PLACE) plan_col[mv.row] = {1'b0, mv.col};
        else if (plan_col[mv.row] == {1'b0, mv.col}) plan_col[mv.row] = EMPTY_COL;
        move_queue.push_back(mv);
    endtask

    task automatic queue_random_moves(int unsigned count, int unsigned span);
        int unsigned r;
        int unsigned pick;
        for (int unsigned k = 0; k < count; k++) begin
            r = $urandom_range(0, span - 1);
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                // search step: lift the row's queen, then drop it in a random column
                if (plan_col[r] != EMPTY_COL) queue_move(OP_REMOVE, r, plan_col[r][9:0]);
                queue_move(OP_PLACE, r, $urandom_range(0, span - 1));
            end else if (pick < 70) begin
                queue_move(OP_PLACE, r, $urandom_range(0, span - 1));
            end else if (pick < 80 && plan_col[r] != EMPTY_COL) begin
                queue_move(OP_REMOVE, r, plan_col[r][9:0]);
            end else if (pick < 90) begin
                queue_move(OP_REMOVE, r, $urandom_range(0, span - 1));
            end else begin
                queue_move($urandom_range(0, 1) ? OP_REMOVE : OP_PLACE,
                           $urandom_range(0, 1023), $urandom_range(0, 1023));
            end
        end
    endtask

    task automatic wait_drained();
        do begin
            @(negedge aclk);
            #1;
        end while (move_queue.size() != 0 || s_tvalid || awaited_outcomes.size() != 0);
    endtask

    task automatic set_board_size(logic [10:0] value);
        wait_drained();
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        board_size_q = value;
        @(negedge aclk);
        cfg_we <= 1'b0;
        n_settings++;
    endtask

    task automatic head_move_load(move_t mv);
        s_tdata <= {3'b000, mv.col, mv.row, mv.op};
    endtask

    // Request driver
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || req_fire) begin
            if (src_wait > 0) begin
                src_wait = src_wait - 1;
                s_tvalid <= 1'b0;
            end else if (move_queue.size() > 0) begin
                head_move_load(move_queue.pop_front());
                s_tvalid <= 1'b1;
                src_wait = $urandom_range(0, src_idle_max);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Result sink back-pressure
    always @(negedge aclk) begin
        if (resp_fire) sink_wait = $urandom_range(0, sink_idle_max);
        if (sink_wait > 0) begin
            sink_wait = sink_wait - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Monitor: check results, then predict accepted requests
    always @(posedge aclk) begin
        move_t mv;
        outcome_t res;
        cycle_count++;
        if (cycle_count >= LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Verification failed");
            $finish;
        end
        req_fire  <= s_tvalid && s_tready;
        resp_fire <= m_tvalid && m_tready;
        if (aresetn && m_tvalid && m_tready) begin
            if (awaited_outcomes.size() == 0) begin
                report_mismatch("result with no request outstanding, data", m_tdata, 0);
            end else begin
                res = awaited_outcomes.pop_front();
                if (m_tdata[0] !== res.ok) report_mismatch("ok", m_tdata[0], res.ok);
                if (m_tdata[12:1] !== res.total)
                    report_mismatch("conflict_total", m_tdata[12:1], res.total);
                if (m_tdata[13] !== res.attacked)
                    report_mismatch("attacked", m_tdata[13], res.attacked);
            end
        end
        if (aresetn && s_tvalid && s_tready) begin
            mv.op  = s_tdata[0];
            mv.row = s_tdata[10:1];
            mv.col = s_tdata[20:11];
            res = apply_move(mv);
            awaited_outcomes.push_back(res);
            if (mv.op == OP_PLACE) n_place++;
            else n_remove++;
            if (!res.ok) n_refused++;
            if (res.attacked) n_attacked++;
            if (res.total > peak_total) peak_total = res.total;
        end
    end

    initial begin
        for (int i = 0; i < MAX_N; i++) begin
            line_row_cnt[i]  = '0;
            line_col_cnt[i]  = '0;
            row_queen_col[i] = '0;
            plan_col[i]      = '0;
        end
        for (int i = 0; i < 2 * MAX_N; i++) begin
            line_sum_cnt[i]  = '0;
            line_diff_cnt[i] = '0;
        end
        conflict_sum = '0;
        board_size_q = 11'd8;

        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: removes on untouched rows, attacks, wrapped coordinates
        queue_move(OP_REMOVE, 3, 0);        // never placed, recorded column is 0
        queue_move(OP_REMOVE, 3, 0);        // row now empty: refused
        queue_move(OP_REMOVE, 4, 5);
        queue_move(OP_PLACE, 0, 0);
        queue_move(OP_PLACE, 1, 1);         // diagonal attack
        queue_move(OP_PLACE, 2, 0);         // column attack
        queue_move(OP_PLACE, 5, 7);
        queue_move(OP_PLACE, 0, 0);         // same cell again
        queue_move(OP_PLACE, 1023, 1023);
        queue_move(OP_PLACE, 0, 1023);      // difference index goes negative
        queue_move(OP_PLACE, 1023, 0);
        queue_move(OP_REMOVE, 1, 1);
        queue_move(OP_REMOVE, 2, 5);        // wrong column
        queue_move(OP_REMOVE, 1023, 1023);
        queue_move(OP_REMOVE, 1023, 1023);
        queue_move(OP_PLACE, 682, 341);
        queue_move(OP_PLACE, 341, 682);
        queue_move(OP_REMOVE, 0, 0);
        queue_move(OP_REMOVE, 0, 1023);
        queue_move(OP_PLACE, 7, 3);

        queue_random_moves(60, 8);

        set_board_size(11'd1);
        src_idle_max = 14; sink_idle_max = 0;
        queue_random_moves(25, 1);

        set_board_size(11'd1024);
        src_idle_max = 0; sink_idle_max = 14;
        queue_random_moves(90, 1024);

        set_board_size(11'd0);
        src_idle_max = 0; sink_idle_max = 0;
        queue_random_moves(60, 12);

        set_board_size(11'd2047);
        src_idle_max = 14; sink_idle_max = 14;
        queue_random_moves(60, 40);

        set_board_size(11'($urandom_range(1, 2047)));
        queue_random_moves(80, 64);

        set_board_size(11'd6);
        queue_random_moves(50, 6);

        // Pile queens on one cell so the conflict total climbs steeply
        set_board_size(11'd300);
        src_idle_max = 0; sink_idle_max = 0;
        for (int i = 0; i < 360; i++) queue_move(OP_PLACE, 37, 700);
        queue_move(OP_REMOVE, 37, 700);
        queue_move(OP_REMOVE, 37, 700);
        for (int i = 0; i < 6; i++) begin
            queue_move(OP_PLACE, 37, 700);
            queue_move(OP_REMOVE, 37, 700);
        end
        wait_drained();
        src_idle_max = 14; sink_idle_max = 14;
        queue_random_moves(25, 1024);

        wait_drained();
        repeat (8) @(posedge aclk);
        $display("Ran %0d place and %0d remove requests (%0d refused, %0d attacked)",
                 n_place, n_remove, n_refused, n_attacked);
        $display("Board size rewritten %0d times; peak conflict total %0d",
                 n_settings, peak_total);
        if (mismatch_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
